FILE: hdl/sfrc_pkg.sv
// Shared types and constants for the salted FIFO read cache.
package sfrc_pkg;

  // Fixed field widths of the words on the item channels
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned SALT_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned ACT_W   = 4;

  // Configuration register map (register index, byte address / 4)
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  // Reset value of the active_entries register
  localparam logic [ACT_W-1:0] ACTIVE_ENTRIES_RST = 4'd8;

  // Command codes
  localparam logic CMD_PLAIN  = 1'b0;
  localparam logic CMD_SALTED = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] lookup_index;
    logic [SALT_W-1:0]  salt_in;
    logic [SALT_W-1:0]  fresh_salt;
    logic [DATA_W-1:0]  fill_data;
  } in_word_t;

  typedef struct packed {
    logic [SALT_W-1:0] salt_out;
    logic [DATA_W-1:0] data_out;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } eng_state_t;

endpackage

FILE: hdl/sfrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sfrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/sfrc_engine.sv
// Lookup and fill engine: tag scan over the entry RAM, valid marks, round-robin pointer.
module sfrc_engine #(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned DATA_BYTES = 8,
  parameter int unsigned SALT_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sfrc_pkg::ACT_W-1:0]    active_entries,
  input  logic                          req_valid,
  input  sfrc_pkg::in_word_t            req,
  output logic                          busy,
  output logic                          res_valid,
  output sfrc_pkg::out_word_t           res,
  input  logic                          res_take
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = (SALT_BYTES >= 4) ? 32 : 8 * SALT_BYTES;
  localparam int unsigned DW = 8 * DATA_BYTES;
  localparam int unsigned EW = sfrc_pkg::INDEX_W + SW + DW;

  sfrc_pkg::eng_state_t state, state_next;

  sfrc_pkg::in_word_t req_q;
  logic [CW-1:0]      cnt;
  logic               rd_pend;
  logic [IW-1:0]      rd_addr_q;
  logic               found;
  logic               salt_ok;
  logic [IW-1:0]      found_slot;
  logic [SW-1:0]      found_salt;
  logic [DW-1:0]      found_data;
  logic [ENTRIES-1:0] entry_valid;
  logic [IW-1:0]      next_slot;

  logic               rd_en;
  logic               wr_en;
  logic [EW-1:0]      rd_data;
  logic [EW-1:0]      wr_data;

  logic [sfrc_pkg::INDEX_W-1:0] rd_index;
  logic [SW-1:0]                rd_salt;
  logic [DW-1:0]                rd_dat;
  logic [SW-1:0]                req_salt;
  logic [SW-1:0]                req_fresh;
  logic [DW-1:0]                req_data;

  logic [NW-1:0] act_n;
  logic [IW-1:0] fill_slot;
  logic [NW-1:0] fill_plus;
  logic [IW-1:0] slot_after;
  logic          is_hit;
  logic          scan_done;

  assign rd_index  = rd_data[EW-1 -: sfrc_pkg::INDEX_W];
  assign rd_salt   = rd_data[DW +: SW];
  assign rd_dat    = rd_data[DW-1:0];
  assign req_salt  = req_q.salt_in[SW-1:0];
  assign req_fresh = req_q.fresh_salt[SW-1:0];
  assign req_data  = req_q.fill_data[DW-1:0];
  assign wr_data   = {req_q.lookup_index, req_fresh, req_data};

  // Clamp the active count to 1..ENTRIES
  always_comb begin
    if (active_entries == '0) begin
      act_n = NW'(1);
    end else if (32'(active_entries) > ENTRIES) begin
      act_n = NW'(ENTRIES);
    end else begin
      act_n = NW'(active_entries);
    end
  end

  // Round-robin slot; wrap to slot 0 if the pointer lies beyond a lowered count
  always_comb begin
    if (NW'(next_slot) >= act_n) begin
      fill_slot = '0;
    end else begin
      fill_slot = next_slot;
    end
    fill_plus = NW'(fill_slot) + NW'(1);
    if (fill_plus == act_n) begin
      slot_after = '0;
    end else begin
      slot_after = IW'(fill_plus);
    end
  end

  assign is_hit    = (req_q.cmd == sfrc_pkg::CMD_SALTED) && found && salt_ok;
  assign scan_done = (cnt == CW'(ENTRIES)) && !rd_pend;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sfrc_pkg::ST_IDLE: begin
        if (req_valid) state_next = sfrc_pkg::ST_SCAN;
      end
      sfrc_pkg::ST_SCAN: begin
        if (scan_done) state_next = sfrc_pkg::ST_RESP;
      end
      sfrc_pkg::ST_RESP: begin
        if (res_take) state_next = sfrc_pkg::ST_IDLE;
      end
      default: state_next = sfrc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy      = 1'b1;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    case (state)
      sfrc_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      sfrc_pkg::ST_SCAN: begin
        rd_en = (cnt != CW'(ENTRIES));
      end
      sfrc_pkg::ST_RESP: begin
        res_valid = 1'b1;
        wr_en     = res_take && !is_hit;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (is_hit) begin
      res.salt_out = 32'(found_salt);
      res.data_out = 64'(found_data);
      res.hit      = 1'b1;
      res.slot     = sfrc_pkg::SLOT_W'(found_slot);
    end else begin
      res.salt_out = 32'(req_fresh);
      res.data_out = 64'(req_data);
      res.hit      = 1'b0;
      res.slot     = sfrc_pkg::SLOT_W'(fill_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sfrc_pkg::ST_IDLE;
      entry_valid <= '0;
      next_slot   <= '0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      case (state)
        sfrc_pkg::ST_IDLE: begin
          if (req_valid) begin
            cnt     <= '0;
            rd_pend <= 1'b0;
            found   <= 1'b0;
          end
        end
        sfrc_pkg::ST_SCAN: begin
          if (rd_en) cnt <= cnt + CW'(1);
          rd_pend <= rd_en;
          // At most one valid entry per index, so the first match is the only one
          if (rd_pend && entry_valid[rd_addr_q] && rd_index == req_q.lookup_index) begin
            found <= 1'b1;
          end
        end
        sfrc_pkg::ST_RESP: begin
          if (wr_en) begin
            // Drop the older mapping, then claim the fill slot
            if (found) entry_valid[found_slot] <= 1'b0;
            entry_valid[fill_slot] <= 1'b1;
            next_slot              <= slot_after;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == sfrc_pkg::ST_IDLE && req_valid) begin
      req_q <= req;
    end
    rd_addr_q <= cnt[IW-1:0];
    if (state == sfrc_pkg::ST_SCAN && rd_pend && entry_valid[rd_addr_q]
        && rd_index == req_q.lookup_index) begin
      found_slot <= rd_addr_q;
      salt_ok    <= (rd_salt == req_salt);
      found_salt <= rd_salt;
      found_data <= rd_dat;
    end
  end

  sfrc_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_slot),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

endmodule

FILE: hdl/salted_fifo_read_cache_top.sv
// Top level of the salted FIFO read cache: APB register, item channels, output register.
// Flow: the engine reads all ENTRIES tags through the single read port of the entry RAM,
//   compares the last read, winds the scan down, then loads the result word into the
//   output register from its response state once that register is free. A new word is
//   taken only in the idle state that follows, never while the last one is in flight.
// Reset (rst, synchronous): clears all valid marks, the round-robin pointer and the
//   output valid flag; active_entries returns to 8. RAM contents are left as they are.
module salted_fifo_read_cache_top #(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned DATA_BYTES = 8,
  parameter int unsigned SALT_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst,
  // input item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  sfrc_pkg::in_word_t  in_word,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output sfrc_pkg::out_word_t out_word,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [sfrc_pkg::ACT_W-1:0] active_entries;
  logic                       cfg_wr;
  logic                       eng_busy;
  logic                       res_valid;
  logic                       res_take;
  sfrc_pkg::out_word_t        res;

  // Configuration: single register at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == sfrc_pkg::REG_ACTIVE_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= sfrc_pkg::ACTIVE_ENTRIES_RST;
    end else if (cfg_wr) begin
      active_entries <= pwdata[sfrc_pkg::ACT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == sfrc_pkg::REG_ACTIVE_ENTRIES) begin
      prdata = 32'(active_entries);
    end else begin
      prdata = '0;
    end
  end

  // Hold input off while the engine works on an item; the engine takes the word
  // straight off the port in its idle cycle.
  assign in_stall = eng_busy;

  // Output register: load a finished result whenever the slot is empty or draining,
  // so the engine is free for the next word while this one waits downstream.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_word <= res;
    end
  end

  sfrc_engine #(
    .ENTRIES    (ENTRIES),
    .DATA_BYTES (DATA_BYTES),
    .SALT_BYTES (SALT_BYTES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .active_entries (active_entries),
    .req_valid      (in_valid),
    .req            (in_word),
    .busy           (eng_busy),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take)
  );

endmodule

FILE: hdl/sfrc_checker.sv
// Port-level checks for the salted FIFO read cache, bound to the top level.
module sfrc_checker #(
  parameter int unsigned ENTRIES = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sfrc_pkg::out_word_t out_word
);

  // One word at a time: input closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A new result appears only while the engine still holds the input off
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a pending item");

  // Reported slot stays inside the cache
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_word.slot) < ENTRIES || ENTRIES >= 8))
    else $error("slot out of range");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

endmodule

bind salted_fifo_read_cache_top sfrc_checker #(.ENTRIES(ENTRIES)) u_sfrc_checker (.*);

FILE: tb/tb_salted_fifo_read_cache_top.sv
// Self-checking testbench for the salted FIFO read cache top level.
module tb_salted_fifo_read_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = 8;
  // Scan of all slots plus compare, wind-down and response
  localparam int unsigned LATENCY   = SLOTS + 3;
  // Watchdog bound, several times the slowest pass of the whole test
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned HOLD_CYC  = 300;
  localparam int unsigned PHASE_LEN = 250;

  // Cache predictor plus the queue of result words still owed by the block
  class cache_scoreboard;
    bit                         valid_mark[SLOTS];
    bit [sfrc_pkg::INDEX_W-1:0] idx_tab[SLOTS];
    bit [sfrc_pkg::SALT_W-1:0]  salt_tab[SLOTS];
    bit [sfrc_pkg::DATA_W-1:0]  data_tab[SLOTS];
    int unsigned                fill_ptr;
    int unsigned                active_reg;
    sfrc_pkg::out_word_t        owed[$];
    int                         errors;

    function void clear();
      foreach (valid_mark[i]) valid_mark[i] = 1'b0;
      fill_ptr   = 0;
      active_reg = sfrc_pkg::ACTIVE_ENTRIES_RST;
      errors     = 0;
    endfunction

    function void set_active(int unsigned v);
      active_reg = v & 32'hF;
    endfunction

    function int pick_valid();
      int cand[$];
      foreach (valid_mark[i]) if (valid_mark[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Work out the result of one accepted word and advance the cache state
    function void note_input(sfrc_pkg::in_word_t w);
      sfrc_pkg::out_word_t e;
      int unsigned         n;
      int unsigned         s;
      bit                  served;
      n = active_reg;
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      served = 1'b0;
      if (w.cmd == sfrc_pkg::CMD_SALTED) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_mark[i] && idx_tab[i] == w.lookup_index) begin
            if (salt_tab[i] == w.salt_in) begin
              e.salt_out = salt_tab[i];
              e.data_out = data_tab[i];
              e.hit      = 1'b1;
              e.slot     = sfrc_pkg::SLOT_W'(i);
              served     = 1'b1;
            end
            break;
          end
        end
      end
      if (!served) begin
        s = fill_ptr;
        if (s >= n) s = 0;
        for (int i = 0; i < SLOTS; i++)
          if (valid_mark[i] && idx_tab[i] == w.lookup_index) valid_mark[i] = 1'b0;
        valid_mark[s] = 1'b1;
        idx_tab[s]    = w.lookup_index;
        salt_tab[s]   = w.fresh_salt;
        data_tab[s]   = w.fill_data;
        fill_ptr      = (s + 1) % n;
        e.salt_out    = w.fresh_salt;
        e.data_out    = w.fill_data;
        e.hit         = 1'b0;
        e.slot        = sfrc_pkg::SLOT_W'(s);
      end
      owed.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] exp);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp);
      errors++;
    endtask

    task check_result(sfrc_pkg::out_word_t got);
      sfrc_pkg::out_word_t e;
      if (owed.size() == 0) begin
        report("unexpected result word", got.data_out, '0);
        return;
      end
      e = owed.pop_front();
      if (got.salt_out !== e.salt_out)
        report("salt_out", 64'(got.salt_out), 64'(e.salt_out));
      if (got.data_out !== e.data_out) report("data_out", got.data_out, e.data_out);
      if (got.hit !== e.hit)           report("hit", 64'(got.hit), 64'(e.hit));
      if (got.slot !== e.slot)         report("slot", 64'(got.slot), 64'(e.slot));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  sfrc_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  sfrc_pkg::out_word_t out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  cache_scoreboard            sb;
  int unsigned                cycles;
  int unsigned                send_gap_max;
  int unsigned                recv_stall_max;
  bit                         hold_req;
  bit [sfrc_pkg::INDEX_W-1:0] idx_pool[16];

  salted_fifo_read_cache_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: any hang or missing result word ends up here
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result word the moment the handshake completes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
  end

  // Result side: stall a random number of cycles per word, plus one long hold-off on request
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    wait (cycles > 0 && !rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold off long enough for the block to back up and stall its input
        out_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, recv_stall_max);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic sfrc_pkg::in_word_t mk(logic c, logic [31:0] idx, logic [31:0] salt,
                                            logic [31:0] fresh, logic [63:0] data);
    sfrc_pkg::in_word_t w;
    w.cmd          = c;
    w.lookup_index = idx;
    w.salt_in      = salt;
    w.fresh_salt   = fresh;
    w.fill_data    = data;
    return w;
  endfunction

  // Mostly a small pool so indices collide; the rest spans the whole range
  function automatic logic [31:0] pick_index();
    if ($urandom_range(0, 3) != 0) return idx_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Bias toward salted reads of live entries so hits and salt mismatches stay frequent
  function automatic sfrc_pkg::in_word_t rand_word();
    sfrc_pkg::in_word_t w;
    int                 k;
    int                 s;
    w = mk(sfrc_pkg::CMD_PLAIN, pick_index(), $urandom, $urandom, {$urandom, $urandom});
    k = $urandom_range(0, 99);
    s = sb.pick_valid();
    if (k < 45 && s >= 0) begin
      w.cmd          = sfrc_pkg::CMD_SALTED;
      w.lookup_index = sb.idx_tab[s];
      w.salt_in      = sb.salt_tab[s];
    end else if (k < 60 && s >= 0) begin
      // right index, salt off by one bit
      w.cmd          = sfrc_pkg::CMD_SALTED;
      w.lookup_index = sb.idx_tab[s];
      w.salt_in      = sb.salt_tab[s] ^ (32'h1 << $urandom_range(0, 31));
    end else if (k < 75) begin
      w.cmd = sfrc_pkg::CMD_SALTED;
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted; returns at a falling edge
  task automatic send_word(sfrc_pkg::in_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed word, then let the pipeline settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_active(logic [3:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(sfrc_pkg::REG_ACTIVE_ENTRIES) << 2;
    pwdata  = {28'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_active(v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_active();
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = 3'(sfrc_pkg::REG_ACTIVE_ENTRIES) << 2;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[sfrc_pkg::ACT_W-1:0] !== sfrc_pkg::ACT_W'(sb.active_reg))
      sb.report("active_entries readback", 64'(got), 64'(sb.active_reg));
  endtask

  initial begin
    logic [3:0]  act_vals[8];
    int unsigned snd_mx[8];
    int unsigned rcv_mx[8];
    sb = new();
    sb.clear();
    cycles         = 0;
    hold_req       = 1'b0;
    send_gap_max   = 12;
    recv_stall_max = 12;
    act_vals = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7};
    snd_mx   = '{12, 0, 0, 12, 0, 12, 12, 0};
    rcv_mx   = '{12, 12, 12, 0, 0, 12, 0, 12};
    idx_pool[0] = 32'h0000_0000;
    idx_pool[1] = 32'hFFFF_FFFF;
    idx_pool[2] = 32'h8000_0000;
    idx_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 16; i++) idx_pool[i] = $urandom;

    rst     = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset value of the register, field extremes, hits, misses, invalidation
    read_active();
    send_word(mk(sfrc_pkg::CMD_PLAIN, 32'h0, 32'h0, 32'h0, 64'h0));
    send_word(mk(sfrc_pkg::CMD_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'h0, 32'h0, 32'h1234_5678, 64'h1));
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 64'h2));
    // salt mismatch: refill and retire the old entry for that index
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'hFFFF_FFFF, 32'h0, 32'hDEAD_BEEF,
                 64'hAAAA_5555_AAAA_5555));
    // index not present at all
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'h1234_5678, 32'h0, 32'h5555_AAAA,
                 64'h5555_AAAA_5555_AAAA));
    // plain read of a cached index always refills
    send_word(mk(sfrc_pkg::CMD_PLAIN, 32'h0, 32'h0, 32'hA5A5_A5A5, 64'h0123_4567_89AB_CDEF));
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'h0, 32'hA5A5_A5A5, 32'h0, 64'h0));
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'h0, 32'h0, 32'h0F0F_0F0F, 64'hFEDC_BA98_7654_3210));
    // walk the fill pointer around the end and on to slot 5
    for (int i = 0; i < 7; i++)
      send_word(mk(sfrc_pkg::CMD_PLAIN, 32'd100 + i, 32'h0, $urandom, {$urandom, $urandom}));
    drain();
    // shrink below the fill pointer: next fill wraps to slot 0
    write_active(4'd3);
    read_active();
    // entry in slot 5 lies beyond the active count but still serves a hit
    send_word(mk(sfrc_pkg::CMD_SALTED, 32'h0, 32'h0F0F_0F0F, 32'h0, 64'h0));
    send_word(mk(sfrc_pkg::CMD_PLAIN, 32'd200, 32'h0, 32'h8000_0001, 64'h8000_0000_0000_0001));
    drain();

    // Random phases, each under its own register value and idle pattern
    for (int p = 0; p < 8; p++) begin
      write_active(act_vals[p]);
      read_active();
      send_gap_max   = snd_mx[p];
      recv_stall_max = rcv_mx[p];
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;
        // pause input mid-phase until every owed word is back
        if (p == 5 && i == PHASE_LEN / 2) drain();
        send_word(rand_word());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
